// ----- rtl/sem_pkg.sv -----
// ----------------------------------------------------------------------------
// sem_pkg: shared types and constants of the Sobel edge magnitude unit
// Datapath widths, register map and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int MaxLinePixelsDefault = 1024;

  // fixed field widths
  localparam int WidthRegW  = 11;
  localparam int HeightRegW = 13;
  localparam int RowW       = 14;   // row counter reaches height+1
  localparam int PixW       = 24;
  localparam int GradW      = 12;   // signed, |g| <= 1020
  localparam int SumW       = 21;   // gx^2 + gy^2 <= 2080800
  localparam int AccW       = 22;
  localparam int RootSteps  = 11;   // two bits of the sum per step
  localparam int CntW       = 4;

  localparam logic [WidthRegW-1:0]  WidthReset  = 11'd640;
  localparam logic [HeightRegW-1:0] HeightReset = 13'd480;

  // register map, index taken from paddr[2]
  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } sem_reg_e;

  // per-item command bundle to the datapath
  typedef struct packed {
    logic load;       // item accepted: latch pixel, read line stores
    logic rd;         // line store data valid: build column, first shift
    logic top_en;
    logic mid_en;
    logic bot_en;
    logic zshift;     // first column of a row: shift in zeros first
    logic dshift;     // first column without a result: both shifts at once
    logic last;       // result closes the frame
    logic calc;       // latch gradients, second shift or window clear
    logic sq;         // squares and root init
    logic root_step;
    logic fin;        // round, clamp, load output register
    logic restart;    // clear the window
  } sem_cmd_t;

endpackage

// ----- rtl/sobel_edge_magnitude_rgb_unit.sv -----
// An item with a result passes the line store read, gradient, squares, the 11-step square root
// on the three lanes and the rounding before it can be taken; an item without a result ends after the line store read.
// One item is in work at a time: a new item is accepted only once the last one is taken or done.
// Reset (rst_ni, async low) clears position, window and control, and loads
// width 640 and height 480; the line stores are not cleared.
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_unit: Sobel 3x3 edge magnitude on RGB pixels
// Streaming raster input, APB register port, rounded gradient magnitude out.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb_unit
  import sem_pkg::*;
#(
  parameter int MAX_LINE_PIXELS = MaxLinePixelsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_edge_o,
  output logic [7:0]  green_edge_o,
  output logic [7:0]  blue_edge_o,
  output logic        frame_end_o
);

  localparam int AW = $clog2(MAX_LINE_PIXELS);

  sem_cmd_t              cmd;
  logic [AW-1:0]         addr;
  logic [WidthRegW-1:0]  width;
  logic [HeightRegW-1:0] height;
  logic                  cfg_we;
  sem_reg_e              cfg_idx;

  // register access
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = sem_reg_e'(paddr[2]);
  always_comb begin
    case (cfg_idx)
      REG_WIDTH:  prdata = 32'(width);
      REG_HEIGHT: prdata = 32'(height);
      default:    prdata = '0;
    endcase
  end

  sem_ctrl #(
    .MAX_LINE_PIXELS(MAX_LINE_PIXELS),
    .AW(AW)
  ) u_ctrl (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_data_i(pwdata),
    .width_o(width),
    .height_o(height),
    .addr_o(addr),
    .cmd_o(cmd)
  );

  sem_dp #(
    .MAX_LINE_PIXELS(MAX_LINE_PIXELS),
    .AW(AW)
  ) u_dp (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cmd_i(cmd),
    .addr_i(addr),
    .action_i(action_i),
    .red_in_i(red_in_i),
    .green_in_i(green_in_i),
    .blue_in_i(blue_in_i),
    .red_edge_o(red_edge_o),
    .green_edge_o(green_edge_o),
    .blue_edge_o(blue_edge_o),
    .frame_end_o(frame_end_o)
  );

endmodule

// ----- rtl/sem_ctrl.sv -----
// ----------------------------------------------------------------------------
// sem_ctrl: sequencing controller
// Holds the frame position and registers, and steps each item through
// line store read, window update, gradient, squares, root and output.
// ----------------------------------------------------------------------------
module sem_ctrl
  import sem_pkg::*;
#(
  parameter int MAX_LINE_PIXELS = MaxLinePixelsDefault,
  parameter int AW = $clog2(MAX_LINE_PIXELS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  logic                  cfg_we_i,
  input  sem_reg_e              cfg_idx_i,
  input  logic [31:0]           cfg_data_i,
  output logic [WidthRegW-1:0]  width_o,
  output logic [HeightRegW-1:0] height_o,
  output logic [AW-1:0]         addr_o,
  output sem_cmd_t              cmd_o
);

  localparam int CW = $clog2(MAX_LINE_PIXELS + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_CALC = 7'b0000100,
    S_SQ   = 7'b0001000,
    S_ROOT = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_OUT  = 7'b1000000
  } sem_state_e;

  sem_state_e state_q, state_d;
  logic [WidthRegW-1:0]  width_q;
  logic [HeightRegW-1:0] height_q;
  logic [AW-1:0]   col_q;
  logic [RowW-1:0] row_q;
  logic [CntW-1:0] cnt_q;
  logic top_q, mid_q, bot_q, zs_q, emit_q, last_q;

  logic [CW-1:0]         eff_w;
  logic [HeightRegW-1:0] eff_h;
  logic [AW-1:0]         c_use;
  logic [CW-1:0]         c_next;
  logic                  accept, cz, emit_d, last_d;

  // effective sizes
  always_comb begin
    if (width_q == '0) begin
      eff_w = CW'(1);
    end else if (32'(width_q) > 32'(MAX_LINE_PIXELS)) begin
      eff_w = CW'(MAX_LINE_PIXELS);
    end else begin
      eff_w = CW'(width_q);
    end
    eff_h = (height_q == '0) ? HeightRegW'(1) : height_q;
  end

  assign accept = in_valid_i && in_ready_o;
  assign c_use  = (CW'(col_q) >= eff_w) ? '0 : col_q;
  assign c_next = CW'(c_use) + CW'(1);
  assign cz     = (c_use == '0);
  assign emit_d = cz ? (row_q >= RowW'(2)) : (row_q >= RowW'(1));
  assign last_d = cz && (row_q == (RowW'(eff_h) + RowW'(1)));
  assign addr_o = c_use;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_RD;
      S_RD:   state_d = emit_q ? S_CALC : S_IDLE;
      S_CALC: state_d = S_SQ;
      S_SQ:   state_d = S_ROOT;
      S_ROOT: if (cnt_q == CntW'(RootSteps - 1)) state_d = S_FIN;
      S_FIN:  state_d = S_OUT;
      S_OUT:  if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // state, positions, registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      width_q  <= WidthReset;
      height_q <= HeightReset;
      col_q    <= '0;
      row_q    <= '0;
      cnt_q    <= '0;
      top_q    <= 1'b0;
      mid_q    <= 1'b0;
      bot_q    <= 1'b0;
      zs_q     <= 1'b0;
      emit_q   <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_ROOT) begin
        cnt_q <= cnt_q + CntW'(1);
      end else begin
        cnt_q <= '0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WIDTH:  width_q  <= cfg_data_i[WidthRegW-1:0];
          REG_HEIGHT: height_q <= cfg_data_i[HeightRegW-1:0];
          default: ;
        endcase
        col_q <= '0;
        row_q <= '0;
      end else if (accept) begin
        top_q  <= (row_q >= RowW'(2));
        mid_q  <= (row_q >= RowW'(1));
        bot_q  <= (row_q < RowW'(eff_h));
        zs_q   <= cz;
        emit_q <= emit_d;
        last_q <= last_d;
        if (last_d) begin
          col_q <= '0;
          row_q <= '0;
        end else if (c_next >= eff_w) begin
          col_q <= '0;
          row_q <= row_q + RowW'(1);
        end else begin
          col_q <= c_next[AW-1:0];
        end
      end
    end
  end

  // commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = accept;
    cmd_o.rd        = (state_q == S_RD);
    cmd_o.top_en    = top_q;
    cmd_o.mid_en    = mid_q;
    cmd_o.bot_en    = bot_q;
    cmd_o.zshift    = zs_q;
    cmd_o.dshift    = zs_q && !emit_q;
    cmd_o.last      = last_q;
    cmd_o.calc      = (state_q == S_CALC);
    cmd_o.sq        = (state_q == S_SQ);
    cmd_o.root_step = (state_q == S_ROOT);
    cmd_o.fin       = (state_q == S_FIN);
    cmd_o.restart   = cfg_we_i;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign width_o     = width_q;
  assign height_o    = height_q;

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output sides active together");
  a_root_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROOT) |-> (cnt_q < CntW'(RootSteps)))
    else $error("root step count overrun");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped before taken");
  a_fin_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |=> out_valid_o)
    else $error("finished result not presented");
`endif

endmodule

// ----- rtl/sem_dp.sv -----
// ----------------------------------------------------------------------------
// sem_dp: Sobel datapath
// Two line stores, 3x3 window, gradient and square stages, and a
// digit-by-digit rounded square root on three color lanes.
// ----------------------------------------------------------------------------
module sem_dp
  import sem_pkg::*;
#(
  parameter int MAX_LINE_PIXELS = MaxLinePixelsDefault,
  parameter int AW = $clog2(MAX_LINE_PIXELS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sem_cmd_t      cmd_i,
  input  logic [AW-1:0] addr_i,
  input  logic          action_i,
  input  logic [7:0]    red_in_i,
  input  logic [7:0]    green_in_i,
  input  logic [7:0]    blue_in_i,
  output logic [7:0]    red_edge_o,
  output logic [7:0]    green_edge_o,
  output logic [7:0]    blue_edge_o,
  output logic          frame_end_o
);

  logic [PixW-1:0] upper_mem [MAX_LINE_PIXELS];
  logic [PixW-1:0] middle_mem [MAX_LINE_PIXELS];
  logic [PixW-1:0] up_rd_q, mid_rd_q, pix_q;
  logic [AW-1:0]   addr_q;
  logic [PixW-1:0] top, mid, bot;
  logic [PixW-1:0] win_q [3][3];   // [row][column], column 2 newest
  logic [PixW-1:0] colv_q [3];

  logic signed [GradW-1:0] gx_q [3], gy_q [3];
  logic [AccW-1:0] op_q [3], res_q [3];
  logic [AccW-1:0] one_q;
  logic [7:0]      edge_q [3];
  logic            fe_q;

  // column entering the window
  assign top = cmd_i.top_en ? up_rd_q  : '0;
  assign mid = cmd_i.mid_en ? mid_rd_q : '0;
  assign bot = cmd_i.bot_en ? pix_q    : '0;

  // line stores: read on accept, write back when the column is built
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      up_rd_q  <= upper_mem[addr_i];
      mid_rd_q <= middle_mem[addr_i];
      addr_q   <= addr_i;
      pix_q    <= action_i ? '0 : {red_in_i, green_in_i, blue_in_i};
    end
    if (cmd_i.rd) begin
      upper_mem[addr_q]  <= mid;
      middle_mem[addr_q] <= bot;
    end
  end

  // window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        colv_q[r] <= '0;
        for (int k = 0; k < 3; k++) win_q[r][k] <= '0;
      end
    end else if (cmd_i.restart || (cmd_i.calc && cmd_i.last)) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) win_q[r][k] <= '0;
      end
    end else if (cmd_i.rd) begin
      colv_q[0] <= top;
      colv_q[1] <= mid;
      colv_q[2] <= bot;
      // no result at a row start: zero column and new column in one step
      if (cmd_i.dshift) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= win_q[r][2];
          win_q[r][1] <= '0;
        end
      end else begin
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= win_q[r][1];
          win_q[r][1] <= win_q[r][2];
        end
      end
      win_q[0][2] <= (cmd_i.zshift && !cmd_i.dshift) ? '0 : top;
      win_q[1][2] <= (cmd_i.zshift && !cmd_i.dshift) ? '0 : mid;
      win_q[2][2] <= (cmd_i.zshift && !cmd_i.dshift) ? '0 : bot;
    end else if (cmd_i.calc && cmd_i.zshift) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
        win_q[r][2] <= colv_q[r];
      end
    end
  end

  // gradients, squares, root and output, one lane per color
  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < 3; ch++) begin
      logic signed [GradW-1:0] p [3][3];
      logic [AccW-1:0] sum, q;
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          p[r][k] = GradW'(win_q[r][k][16-8*ch +: 8]);
        end
      end
      sum = res_q[ch] + one_q;
      q   = res_q[ch];
      if (cmd_i.calc) begin
        gx_q[ch] <= GradW'((p[0][2] - p[0][0]) + 2 * (p[1][2] - p[1][0])
                           + (p[2][2] - p[2][0]));
        gy_q[ch] <= GradW'((p[2][0] + 2 * p[2][1] + p[2][2])
                           - (p[0][0] + 2 * p[0][1] + p[0][2]));
      end
      if (cmd_i.sq) begin
        op_q[ch]  <= AccW'(SumW'(gx_q[ch] * gx_q[ch]) + SumW'(gy_q[ch] * gy_q[ch]));
        res_q[ch] <= '0;
      end else if (cmd_i.root_step) begin
        if (op_q[ch] >= sum) begin
          op_q[ch]  <= op_q[ch] - sum;
          res_q[ch] <= (res_q[ch] >> 1) + one_q;
        end else begin
          res_q[ch] <= res_q[ch] >> 1;
        end
      end
      if (cmd_i.fin) begin
        if (op_q[ch] > q) q = q + AccW'(1);
        edge_q[ch] <= (q > AccW'(255)) ? 8'hFF : q[7:0];
      end
    end
    if (cmd_i.sq) begin
      one_q <= AccW'(1) << (2 * (RootSteps - 1));
    end else if (cmd_i.root_step) begin
      one_q <= one_q >> 2;
    end
    if (cmd_i.fin) fe_q <= cmd_i.last;
  end

  assign red_edge_o   = edge_q[0];
  assign green_edge_o = edge_q[1];
  assign blue_edge_o  = edge_q[2];
  assign frame_end_o  = fe_q;

endmodule
